// ----- src/assert_macros.svh -----
// Assertion macros for the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ----- src/rtm_pkg.sv -----
// Types and constants for the range table membership block
`timescale 1ns / 1ps

package rtm_pkg;

    localparam logic [1:0] REQ_APPEND = 2'd0;
    localparam logic [1:0] REQ_QUERY  = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]          req_type;
        logic signed [31:0]  range_low;
        logic signed [31:0]  range_high;
        logic signed [31:0]  query_value;
    } in_t;

    typedef struct packed {
        logic in_range;
        logic table_full;
    } out_t;

    typedef struct packed {
        logic signed [31:0] low;
        logic signed [31:0] high;
    } entry_t;

    typedef struct packed {
        logic start;
        logic vld;
    } scan_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_DONE
    } state_t;

endpackage

// ----- src/rtm_table.sv -----
// Range storage: one write port, one registered read port
`timescale 1ns / 1ps

module rtm_table #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  rtm_pkg::entry_t wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output rtm_pkg::entry_t rd_data
);
    import rtm_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/rtm_scan.sv -----
// Shared compare unit: tracks best low and high bounds over a scan
`timescale 1ns / 1ps

module rtm_scan #(
    parameter int AW = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rtm_pkg::scan_ctrl_t ctrl,
    input  logic signed [31:0]  query,
    input  rtm_pkg::entry_t     ent,
    input  logic [AW-1:0]       ent_idx,
    output logic                hit
);
    import rtm_pkg::*;

    logic signed [31:0] query_reg;
    logic signed [31:0] best_low_reg;
    logic signed [31:0] best_low_next;
    logic signed [31:0] best_high_reg;
    logic signed [31:0] best_high_next;
    logic [AW-1:0]      low_idx_reg;
    logic [AW-1:0]      low_idx_next;
    logic [AW-1:0]      high_idx_reg;
    logic [AW-1:0]      high_idx_next;
    logic               have_low_reg;
    logic               have_low_next;
    logic               have_high_reg;
    logic               have_high_next;
    logic               take_low;
    logic               take_high;

    // ties go to the later entry
    assign take_low  = ctrl.vld && (ent.low <= query_reg)
                       && (!have_low_reg || ent.low >= best_low_reg);
    assign take_high = ctrl.vld && (ent.high >= query_reg)
                       && (!have_high_reg || ent.high <= best_high_reg);

    always_comb
    begin
        have_low_next  = have_low_reg;
        have_high_next = have_high_reg;
        best_low_next  = best_low_reg;
        best_high_next = best_high_reg;
        low_idx_next   = low_idx_reg;
        high_idx_next  = high_idx_reg;
        if (ctrl.start)
        begin
            have_low_next  = 1'b0;
            have_high_next = 1'b0;
        end
        else
        begin
            if (take_low)
            begin
                have_low_next = 1'b1;
                best_low_next = ent.low;
                low_idx_next  = ent_idx;
            end
            if (take_high)
            begin
                have_high_next = 1'b1;
                best_high_next = ent.high;
                high_idx_next  = ent_idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_low_reg  <= 1'b0;
            have_high_reg <= 1'b0;
        end
        else
        begin
            have_low_reg  <= have_low_next;
            have_high_reg <= have_high_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            query_reg <= query;
        end
        best_low_reg  <= best_low_next;
        best_high_reg <= best_high_next;
        low_idx_reg   <= low_idx_next;
        high_idx_reg  <= high_idx_next;
    end

    assign hit = have_low_reg && have_high_reg && (low_idx_reg == high_idx_reg);

endmodule

// ----- src/range_table_membership.sv -----
// Top level of the range table membership block
// Append, clear and unused codes: result is registered in the cycle after the beat.
// Query: one entry a cycle is read from the single memory read port and checked by the
// shared compare unit in SCAN; WAIT and DONE follow and DONE loads the result. Queries
// on an empty table answer in the cycle after the beat. A new beat is taken only in IDLE
// with no stalled response. Reset (rst_n, async, low) empties the table.
`timescale 1ns / 1ps

module range_table_membership #(
    parameter int DEPTH = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  rtm_pkg::in_t  req_data,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output rtm_pkg::out_t rsp_data
);
    import rtm_pkg::*;

`include "assert_macros.svh"

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    state_t        state_reg;
    state_t        state_next;
    logic [CW-1:0] entry_count_reg;
    logic [CW-1:0] entry_count_next;
    logic [AW-1:0] rd_idx_reg;
    logic [AW-1:0] rd_idx_next;
    logic [AW-1:0] rd_idx_dly_reg;
    logic          rd_vld_reg;
    logic          rsp_valid_reg;
    logic          rsp_valid_next;
    out_t          rsp_reg;
    out_t          rsp_next;

    logic          accept;
    logic          is_query;
    logic          last_rd;
    logic          table_has_room;
    logic          wr_en;
    logic          rd_en;
    logic          rsp_load;
    scan_ctrl_t    scan_ctrl;
    entry_t        wr_entry;
    entry_t        rd_entry;
    logic          hit;

    assign req_stall      = (state_reg != ST_IDLE) || (rsp_valid_reg && rsp_stall);
    assign accept         = req_valid && !req_stall;
    assign is_query       = (req_data.req_type == REQ_QUERY);
    assign table_has_room = (entry_count_reg < CW'(DEPTH));
    assign last_rd        = (CW'(rd_idx_reg) == entry_count_reg - CW'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_query && entry_count_reg != '0)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last_rd)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: state_next = ST_DONE;
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        wr_en            = 1'b0;
        rd_en            = 1'b0;
        scan_ctrl.start  = 1'b0;
        scan_ctrl.vld    = rd_vld_reg;
        rsp_load         = 1'b0;
        rsp_next         = '0;
        entry_count_next = entry_count_reg;
        rd_idx_next      = rd_idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_data.req_type)
                        REQ_APPEND:
                        begin
                            rsp_load = 1'b1;
                            if (table_has_room)
                            begin
                                wr_en            = 1'b1;
                                entry_count_next = entry_count_reg + CW'(1);
                            end
                            else
                            begin
                                rsp_next.table_full = 1'b1;
                            end
                        end
                        REQ_QUERY:
                        begin
                            scan_ctrl.start = 1'b1;
                            rd_idx_next     = '0;
                            if (entry_count_reg == '0)
                            begin
                                rsp_load = 1'b1;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            rsp_load         = 1'b1;
                            entry_count_next = '0;
                        end
                        default: rsp_load = 1'b1;
                    endcase
                end
            end
            ST_SCAN:
            begin
                rd_en       = 1'b1;
                rd_idx_next = rd_idx_reg + AW'(1);
            end
            ST_WAIT: ;
            ST_DONE:
            begin
                rsp_load          = 1'b1;
                rsp_next.in_range = hit;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            entry_count_reg <= '0;
            rd_vld_reg      <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            rd_vld_reg      <= rd_en;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg     <= rd_idx_next;
        rd_idx_dly_reg <= rd_idx_reg;
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign wr_entry.low  = req_data.range_low;
    assign wr_entry.high = req_data.range_high;

    rtm_table #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (entry_count_reg[AW-1:0]),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_entry)
    );

    rtm_scan #(
        .AW (AW)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (scan_ctrl),
        .query   (req_data.query_value),
        .ent     (rd_entry),
        .ent_idx (rd_idx_dly_reg),
        .hit     (hit)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    `ASSERT_NEVER(a_count_bound, clk, rst_n, entry_count_reg > CW'(DEPTH))
    `ASSERT_CLK(a_scan_in_table, clk, rst_n, state_reg == ST_SCAN |-> CW'(rd_idx_reg) < entry_count_reg)
    `ASSERT_CLK(a_wait_has_data, clk, rst_n, (state_reg == ST_WAIT) |-> rd_vld_reg)
    `ASSERT_CLK(a_done_loads_rsp, clk, rst_n, (state_reg == ST_DONE) |=> rsp_valid_reg)
    `ASSERT_NEVER(a_rsp_free_at_done, clk, rst_n, (state_reg == ST_DONE) && rsp_valid_reg)

endmodule
